### rtl/core/assert_macros.svh
// Assertion macros shared by the divider RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define EID_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define EID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/eid_pkg.sv
// Package: shared constants of the estimate-based iterative divider.
`timescale 1ns / 1ps

package eid_pkg;

  // Default operand width.
  localparam int DATA_WIDTH = 32;

  // Reciprocal estimate coefficients: 11 * 2^(k-2) for msb k > 1, 5 * 2^(k-1) for k == 1.
  localparam int COEF_HI = 11;
  localparam int COEF_LO = 5;

endpackage

### rtl/core/eid_in_if.sv
// Interface: operand request channel (dividend, divisor).
`timescale 1ns / 1ps

interface eid_in_if #(
  parameter int W = eid_pkg::DATA_WIDTH
);
  logic         valid;
  logic         ready;
  logic [W-1:0] dividend;
  logic [W-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

### rtl/core/eid_out_if.sv
// Interface: result request channel (quotient, remainder, divide-by-zero flag).
`timescale 1ns / 1ps

interface eid_out_if #(
  parameter int W = eid_pkg::DATA_WIDTH
);
  logic         valid;
  logic         ready;
  logic [W-1:0] quotient;
  logic [W-1:0] remainder;
  logic         divide_by_zero;

  modport source (output valid, output quotient, output remainder, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input divide_by_zero,
                  output ready);
endinterface

### rtl/core/estimate_iterative_divider.sv
// Top level: estimate-based iterative unsigned divider with output register.
`timescale 1ns / 1ps

// Unsigned divider, quotient and remainder of dividend / divisor at DATA_WIDTH
// bits. One request at a time: after an operand request is taken the block
// stays busy until its result is handed to the output register. The partial
// remainder is cut down by a quotient estimate times the divisor on each pass;
// every pass uses the one shared WxW multiplier twice (remainder times the
// reciprocal coefficient, then estimate times divisor) in the states MUL1, EST,
// MUL2, SUB and TEST. The number of passes is none when the divisor exceeds
// the dividend, one or two for divisors near the dividend, up to about W for
// a divisor of one (each pass at least halves the remainder). The next
// request is taken in the cycle after the hand-off. A zero divisor skips the
// loop and returns all-ones quotient, the dividend as remainder and
// divide_by_zero set. The output register lets a new request be taken while a
// finished result still waits on the sink.

`include "assert_macros.svh"

module estimate_iterative_divider #(
  parameter int DATA_WIDTH = eid_pkg::DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  eid_in_if.sink    operands,
  eid_out_if.source results
);

  logic                  core_done;
  logic                  take;
  logic [DATA_WIDTH-1:0] core_q;
  logic [DATA_WIDTH-1:0] core_r;
  logic                  core_dbz;
  logic                  out_valid;

  // Result moves into the output register when the slot is empty or draining.
  assign take = !out_valid || results.ready;

  eid_core #(.W(DATA_WIDTH)) u_core (
    .clk            (clk),
    .rst            (rst),
    .operands       (operands),
    .take           (take),
    .done           (core_done),
    .quotient       (core_q),
    .remainder      (core_r),
    .divide_by_zero (core_dbz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_done && take) begin
      out_valid              <= 1'b1;
      results.quotient       <= core_q;
      results.remainder      <= core_r;
      results.divide_by_zero <= core_dbz;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid = out_valid;

  // Busy right after an accepted request.
  `EID_ASSERT_NEXT(a_busy_after_accept, operands.valid && operands.ready, !operands.ready, "ready after accept")
  // A finished result blocked by a full output slot stays finished.
  `EID_ASSERT_NEXT(a_result_held, core_done && !take, core_done, "result dropped")
  // A handed-off result shows up on the output.
  `EID_ASSERT_NEXT(a_result_loaded, core_done && take, results.valid, "result not loaded")
  // Divide by zero carries an all-ones quotient.
  `EID_ASSERT_SAME(a_dbz_quotient, results.valid && results.divide_by_zero, results.quotient == '1, "bad dbz quotient")

endmodule

### rtl/core/eid_mul.sv
// Shared multiplier: full-width unsigned product, registered.
`timescale 1ns / 1ps

module eid_mul #(
  parameter int W = eid_pkg::DATA_WIDTH
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= {{W{1'b0}}, a} * {{W{1'b0}}, b};
  end

endmodule

### rtl/core/eid_core.sv
// Sequencer and datapath of the divider; drives the shared multiplier.
`timescale 1ns / 1ps

module eid_core #(
  parameter int W = eid_pkg::DATA_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  eid_in_if.sink       operands,
  input  logic         take,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder,
  output logic         divide_by_zero
);

  localparam int LW = $clog2(W);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_CHECK, S_MUL1, S_EST, S_MUL2, S_SUB, S_TEST, S_DONE
  } state_t;

  state_t         state;
  logic [W-1:0]   q;
  logic [W-1:0]   r;
  logic [W-1:0]   n;
  logic [W-1:0]   coef;
  logic [W-1:0]   est;
  logic [LW-1:0]  k;
  logic           dbz;

  logic [W-1:0]   mul_a;
  logic [W-1:0]   mul_b;
  logic [2*W-1:0] prod;

  logic [W+1:0]   coef_wide;
  logic [LW:0]    shamt_alt;
  logic [LW:0]    shamt_est;
  logic [2*W-1:0] alt;
  logic [2*W-1:0] est_shift;
  logic [2*W-1:0] est_full;
  logic           hit;
  logic           r_ge_n;

  function automatic logic [LW-1:0] msb_pos(input logic [W-1:0] v);
    logic [LW-1:0] pos;
    pos = '0;
    for (int i = 0; i < W; i++) begin
      if (v[i]) pos = LW'(i);
    end
    return pos;
  endfunction

  eid_mul #(.W(W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Operand select for the shared multiplier.
  always_comb begin
    case (state)
      S_MUL2: begin
        mul_a = est;
        mul_b = n;
      end
      default: begin
        mul_a = r;
        mul_b = coef;
      end
    endcase
  end

  always_comb begin
    if (k > LW'(1)) begin
      coef_wide = (W+2)'(eid_pkg::COEF_HI) << (k - LW'(2));
    end else begin
      coef_wide = (W+2)'(eid_pkg::COEF_LO);
    end
    coef_wide = coef_wide - {2'b00, n};
  end

  assign shamt_alt = {k, 1'b1};
  assign shamt_est = {1'b0, k} + (LW+1)'(1);
  assign alt       = prod >> shamt_alt;
  assign est_shift = {{W{1'b0}}, r >> shamt_est};
  assign est_full  = ((k != '0) && (alt > est_shift)) ? alt : est_shift;
  assign hit       = (r >> k) == W'(1);
  assign r_ge_n    = r >= n;

  assign operands.ready = (state == S_IDLE);
  assign done           = (state == S_DONE);
  assign quotient       = q;
  assign remainder      = r;
  assign divide_by_zero = dbz;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (operands.valid) begin
            r   <= operands.dividend;
            n   <= operands.divisor;
            q   <= '0;
            dbz <= (operands.divisor == '0);
            if (operands.divisor == '0) begin
              q     <= '1;
              state <= S_DONE;
            end else begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          k     <= msb_pos(n);
          state <= S_CHECK;
        end
        S_CHECK: begin
          coef  <= coef_wide[W-1:0];
          state <= r_ge_n ? S_MUL1 : S_DONE;
        end
        S_MUL1: state <= S_EST;
        S_EST: begin
          est   <= est_full[W-1:0];
          state <= S_MUL2;
        end
        S_MUL2: begin
          q     <= q + est;
          state <= S_SUB;
        end
        S_SUB: begin
          r     <= r - prod[W-1:0];
          state <= S_TEST;
        end
        S_TEST: begin
          if (hit) begin
            // remainder reached the divisor's msb: one final correction
            if (r_ge_n) begin
              q <= q + W'(1);
              r <= r - n;
            end
            state <= S_DONE;
          end else begin
            state <= r_ge_n ? S_MUL1 : S_DONE;
          end
        end
        S_DONE: begin
          if (take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/testbench.sv
// Testbench for the estimate-based iterative divider: directed table, random operands, checker.
`timescale 1ns / 1ps

module testbench;

  localparam int W            = eid_pkg::DATA_WIDTH;
  localparam int STALL_LIMIT  = 20000;  // cycles with no request moving on either side
  localparam int DRAIN_CYCLES = 400;    // longer than the worst divide, plus margin
  localparam int RANDOM_ITEMS = 600;
  localparam int PHASES       = 4;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
    logic         divide_by_zero;
  } division_t;

  // One outstanding divide: operands kept for the error message.
  typedef struct packed {
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    division_t    answer;
  } pending_t;

  // Directed row. When known is set the answer column is the expectation;
  // otherwise the expectation comes from the predictor below.
  typedef struct packed {
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         known;
    division_t    answer;
  } directed_row_t;

  localparam int NUM_DIRECTED = 23;

  logic clk;
  logic rst;

  eid_in_if  #(.W(W)) op_bus ();
  eid_out_if #(.W(W)) res_bus ();

  estimate_iterative_divider #(.DATA_WIDTH(W)) DUT (
    .clk       (clk),
    .rst       (rst),
    .operands  (op_bus),
    .results   (res_bus)
  );

  pending_t  expected_divisions[$];
  pending_t  oldest_division;
  int        mismatch_count;
  int        quiet_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // zero divisor: flag set, all-ones quotient, dividend passed through
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
    '{32'h1234_5678, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 32'h1234_5678, 1'b1}},
    // extremes of both fields
    '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'hFFFF_FFFE, 1'b0}},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h7FFF_FFFF, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0002, 1'b1, '{32'h7FFF_FFFF, 32'h0000_0001, 1'b0}},
    // remainder equal to divisor counts as divisible
    '{32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
    '{32'h0000_0003, 32'h0000_0003, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
    // msb-1 divisors use the short coefficient, then mixed divisors; all checked by the predictor
    '{32'h0000_0007, 32'h0000_0002, 1'b0, '0},
    '{32'h0000_0007, 32'h0000_0003, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'h0000_0003, 1'b0, '0},
    '{32'h0000_03E8, 32'h0000_0007, 1'b0, '0},
    '{32'hDEAD_BEEF, 32'h0001_0001, 1'b0, '0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'h0000_0005, 1'b0, '0},
    '{32'h9999_9999, 32'h0001_2345, 1'b0, '0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{32'h0F0F_0F0F, 32'h0000_F0F1, 1'b0, '0}
  };

  always #5 clk = ~clk;

  // Position of the highest set bit; 0 for a zero word.
  function automatic int msb_index(input logic [W-1:0] value);
    int idx;
    idx = 0;
    for (int i = 0; i < W; i++) begin
      if (value[i]) idx = i;
    end
    return idx;
  endfunction

  // Estimate-and-subtract division. Each pass takes the larger of two lower
  // bounds on rem / divisor: rem >> (k+1) and the linear reciprocal
  // rem * (c * 2^j - divisor) >> (2k+1). Products are kept at full width.
  function automatic division_t predict_division(input logic [W-1:0] dvd,
                                                 input logic [W-1:0] dvs);
    division_t      res;
    logic [W-1:0]   rem;
    logic [W-1:0]   quo;
    logic [2*W-1:0] est;
    logic [2*W-1:0] alt;
    logic [2*W-1:0] coef;
    logic [4*W-1:0] prod;
    int             k;
    int             passes;
    bit             done;
    res.divide_by_zero = 1'b0;
    if (dvs == '0) begin
      res.quotient       = '1;
      res.remainder      = dvd;
      res.divide_by_zero = 1'b1;
      return res;
    end
    k      = msb_index(dvs);
    rem    = dvd;
    quo    = '0;
    passes = 0;
    done   = 1'b0;
    while (!done && rem >= dvs && passes < 2 * W + 8) begin
      passes++;
      est = {{W{1'b0}}, rem} >> (k + 1);
      if (k > 0) begin
        if (k > 1) begin
          coef = ((2 * W)'(eid_pkg::COEF_HI) << (k - 2)) - {{W{1'b0}}, dvs};
        end else begin
          coef = ((2 * W)'(eid_pkg::COEF_LO) << (k - 1)) - {{W{1'b0}}, dvs};
        end
        prod = {{(3 * W){1'b0}}, rem} * {{(2 * W){1'b0}}, coef};
        alt  = prod[2*W-1+2*k+1 -: 2*W];
        if (alt > est) est = alt;
      end
      quo = quo + est[W-1:0];
      rem = rem - est[W-1:0] * dvs;
      // remainder now shares the divisor's msb: one last correction
      if (rem != '0 && msb_index(rem) == k) begin
        if (rem >= dvs) begin
          quo = quo + 1'b1;
          rem = rem - dvs;
        end
        done = 1'b1;
      end
    end
    res.quotient  = quo;
    res.remainder = rem;
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input pending_t p,
                               input logic [W-1:0] got, input logic [W-1:0] want);
    $display("%0t MISMATCH %s: %h / %h got %h want %h",
             $realtime, field, p.dividend, p.divisor, got, want);
    mismatch_count++;
  endtask

  // Mismatch not tied to one compared field.
  task automatic flag_problem(input string text);
    $display("%0t MISMATCH %s", $realtime, text);
    mismatch_count++;
  endtask

  // Operand word with its weight spread over the whole range.
  function automatic logic [W-1:0] random_word();
    logic [W-1:0] w;
    case ($urandom_range(0, 5))
      0:       w = W'({$urandom(), $urandom()});
      1:       w = W'({$urandom(), $urandom()}) >> $urandom_range(0, W - 1);
      2:       w = W'($urandom_range(0, 20));
      3:       w = {W{1'b1}} >> $urandom_range(0, W - 1);
      4:       w = W'(1) << $urandom_range(0, W - 1);
      default: w = W'({$urandom(), $urandom()});
    endcase
    return w;
  endfunction

  // Present one request; the expectation is queued on the accepting edge.
  // valid stays high after acceptance, so back-to-back requests never see
  // a lower-then-raise in the same time step.
  task automatic send_division(input logic [W-1:0] dvd, input logic [W-1:0] dvs,
                               input bit known, input division_t answer);
    pending_t p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      op_bus.valid <= 1'b0;
      @(posedge clk);
    end
    op_bus.valid    <= 1'b1;
    op_bus.dividend <= dvd;
    op_bus.divisor  <= dvs;
    @(posedge clk);
    while (!op_bus.ready) @(posedge clk);
    p.dividend = dvd;
    p.divisor  = dvs;
    p.answer   = known ? answer : predict_division(dvd, dvs);
    expected_divisions.push_back(p);
  endtask

  // Hold the sender off until every outstanding result is back.
  task automatic drain_results();
    op_bus.valid <= 1'b0;
    while (expected_divisions.size() != 0) @(posedge clk);
  endtask

  // Result side: random back-pressure, then compare against the oldest
  // expectation. Inputs sampled here are pre-edge values.
  always @(posedge clk) begin
    res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (expected_divisions.size() == 0) begin
        flag_problem($sformatf("unexpected result q=%h r=%h dbz=%b",
                               res_bus.quotient, res_bus.remainder,
                               res_bus.divide_by_zero));
      end else begin
        oldest_division = expected_divisions.pop_front();
        if (res_bus.quotient !== oldest_division.answer.quotient)
          flag_mismatch("quotient", oldest_division, res_bus.quotient,
                        oldest_division.answer.quotient);
        if (res_bus.remainder !== oldest_division.answer.remainder)
          flag_mismatch("remainder", oldest_division, res_bus.remainder,
                        oldest_division.answer.remainder);
        if (res_bus.divide_by_zero !== oldest_division.answer.divide_by_zero)
          flag_mismatch("divide_by_zero", oldest_division,
                        W'(res_bus.divide_by_zero),
                        W'(oldest_division.answer.divide_by_zero));
      end
    end
  end

  // Watchdog: only cycles in which no request moves on either channel count.
  always @(posedge clk) begin
    if (rst || (op_bus.valid && op_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [W-1:0] dvd;
    logic [W-1:0] dvs;
    clk              = 1'b0;
    rst              = 1'b1;
    op_bus.valid     = 1'b0;
    op_bus.dividend  = '0;
    op_bus.divisor   = '0;
    res_bus.ready    = 1'b0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table at full rate.
    foreach (directed_rows[i]) begin
      send_division(directed_rows[i].dividend, directed_rows[i].divisor,
                    directed_rows[i].known, directed_rows[i].answer);
    end
    drain_results();

    // Random operands in four traffic phases: full rate, sparse sender,
    // heavy receiver back-pressure, and both at moderate rate. Each phase
    // ends with a full drain so the sender also pauses with nothing in flight.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        dvd = random_word();
        case ($urandom_range(0, 19))
          0:       dvs = '0;                         // divide by zero
          1:       dvs = dvd;                        // exact single quotient
          2, 3:    dvs = W'($urandom_range(1, 3));   // long loops, short or no coefficient
          4:       begin                             // dividend a multiple of the divisor
                     dvs = random_word();
                     dvd = dvs * W'($urandom_range(1, 9)) + W'($urandom_range(0, 2)) * dvs;
                   end
          default: dvs = random_word();
        endcase
        send_division(dvd, dvs, 1'b0, '0);
      end
      drain_results();
    end

    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_divisions.size() != 0) begin
      flag_problem($sformatf("%0d results never arrived", expected_divisions.size()));
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
